/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

`define ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`else

`define ASSERT_IMP(label, clk, rst, pre, post)
`define ASSERT_NXT(label, clk, rst, pre, post)

`endif

`endif

/* src/dtq_pkg.sv */
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared constants, codes and control types of the deadline timer queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtq_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int TIME_BITS = 32;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
   localparam int REF_W     = 16;
   localparam int HND_W     = 8;
   localparam int WORD_W    = TIME_BITS + REF_W + HND_W;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_CANCEL = 2'd1,
      OP_TICK   = 2'd2,
      OP_EXPIRE = 2'd3
   } op_type;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_EXPIRY = 1'b1;

   typedef struct packed {
      logic idle;
      logic load;
      logic apply_op;
      logic scan_start;
      logic scan_run;
      logic emit_exp;
      logic emit_status;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic scan_done;
      logic due_expire;
      logic out_free;
   } stat_type;

endpackage

/* src/dtq_req_if.sv */
// ----------------------------------------------------------------------------
// dtq_req_if
// Request channel: one timer operation per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dtq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [3:0]  timer_slot;
   logic [31:0] deadline;
   logic [15:0] owner_ref;
   logic [7:0]  handler_tag;
   logic [31:0] now;

   modport source (
      output valid, opcode, timer_slot, deadline, owner_ref, handler_tag, now,
      input  ready
   );
   modport sink (
      input  valid, opcode, timer_slot, deadline, owner_ref, handler_tag, now,
      output ready
   );
endinterface

/* src/dtq_rsp_if.sv */
// ----------------------------------------------------------------------------
// dtq_rsp_if
// Response channel: expiry beats followed by one status beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dtq_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [3:0]  expired_slot;
   logic [15:0] expired_ref;
   logic [7:0]  expired_handler;
   logic        expire_pending;
   logic        alarm_armed;
   logic [31:0] alarm_delay;
   logic        last;

   modport source (
      output valid, kind, expired_slot, expired_ref, expired_handler,
             expire_pending, alarm_armed, alarm_delay, last,
      input  ready
   );
   modport sink (
      input  valid, kind, expired_slot, expired_ref, expired_handler,
             expire_pending, alarm_armed, alarm_delay, last,
      output ready
   );
endinterface

/* src/deadline_timer_queue_unit.sv */
// ----------------------------------------------------------------------------
// deadline_timer_queue_unit
// Timer slot table with earliest-deadline tracking, alarm arming and expiry.
// ----------------------------------------------------------------------------
// Request beats carry an opcode (start, cancel, alarm tick, expire), a slot,
// its deadline, reference and handler tag, and the current time. Each request
// yields zero or more expiry beats (expire only, earliest deadline first, ties
// lowest slot first) and then one status beat with last set, carrying the
// pending flag and, when a new alarm is armed, its delay from now.
// One request is worked at a time. A request without expiries holds the
// sequencer through the accept state, an update state, a scan of the
// 16-entry slot table through the single registered RAM read port, a decide
// state and the state that loads the status beat. Each expiry beat adds the
// state that loads it, a rescan of the table and a decide state.
// The request side is ready again as soon as the status beat is in the output
// register, so the next request overlaps its delivery.
// A stalled receiver holds the output register; the sequencer waits before
// loading the next beat. Reset clears all slots to inactive, disarms the
// alarm and clears the pending flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module deadline_timer_queue_unit (
   input  logic        clock,
   input  logic        reset,
   dtq_req_if.sink     req_chan,
   dtq_rsp_if.source   rsp_chan
);

   dtq_pkg::cmd_type  cmd;
   dtq_pkg::stat_type stat;

   dtq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   dtq_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

   `ASSERT_NXT(a_busy_after_accept, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   `ASSERT_IMP(a_last_is_status, clock, reset, rsp_chan.valid,
               rsp_chan.last == (rsp_chan.kind == dtq_pkg::KIND_STATUS))
   `ASSERT_IMP(a_emit_into_free, clock, reset, cmd.emit_exp || cmd.emit_status, stat.out_free)

endmodule

/* src/dtq_ram.sv */
// ----------------------------------------------------------------------------
// dtq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/dtq_ctrl.sv */
// ----------------------------------------------------------------------------
// dtq_ctrl
// Sequencer: apply the operation, scan for the earliest deadline, emit beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  dtq_pkg::stat_type stat,
   output dtq_pkg::cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_UPDATE = 6'b000010,
      ST_SCAN   = 6'b000100,
      ST_DECIDE = 6'b001000,
      ST_EXPIRE = 6'b010000,
      ST_STATUS = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.idle = 1'b1;
            if (stat.req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.apply_op   = 1'b1;
            cmd.scan_start = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = stat.due_expire ? ST_EXPIRE : ST_STATUS;
         end
         ST_EXPIRE: begin
            if (stat.out_free) begin
               cmd.emit_exp   = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_STATUS: begin
            if (stat.out_free) begin
               cmd.emit_status = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/dtq_datapath.sv */
// ----------------------------------------------------------------------------
// dtq_datapath
// Slot table, earliest-deadline scan, alarm and pending state, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtq_datapath (
   input  logic              clock,
   input  logic              reset,
   input  dtq_pkg::cmd_type  cmd,
   output dtq_pkg::stat_type stat,
   dtq_req_if.sink           req,
   dtq_rsp_if.source         rsp
);

   localparam int TB = dtq_pkg::TIME_BITS;
   localparam int SW = dtq_pkg::SLOT_W;
   localparam int CW = dtq_pkg::CNT_W;
   localparam int NS = dtq_pkg::NUM_SLOTS;

   // latched request
   dtq_pkg::op_type                op_ff;
   logic [3:0]                     slot_ff;
   logic [TB-1:0]                  dl_ff;
   logic [dtq_pkg::REF_W-1:0]      ref_ff;
   logic [dtq_pkg::HND_W-1:0]      hnd_ff;
   logic [TB-1:0]                  now_ff;

   // queue state
   logic [NS-1:0] active_ff, active_in;
   logic [TB-1:0] armed_time_ff, armed_time_in;
   logic          pending_ff, pending_in;

   // scan
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic                      cmp_valid_ff, cmp_valid_in;
   logic [SW-1:0]             cmp_idx_ff;
   logic                      best_valid_ff, best_valid_in;
   logic [SW-1:0]             best_idx_ff, best_idx_in;
   logic [TB-1:0]             best_dl_ff, best_dl_in;
   logic [dtq_pkg::REF_W-1:0] best_ref_ff, best_ref_in;
   logic [dtq_pkg::HND_W-1:0] best_hnd_ff, best_hnd_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      kind_ff;
   logic [3:0]                exp_slot_ff;
   logic [15:0]               exp_ref_ff;
   logic [7:0]                exp_hnd_ff;
   logic                      pend_out_ff;
   logic                      armed_out_ff;
   logic [31:0]               delay_out_ff;
   logic                      last_ff;

   // table memory
   logic                         ram_we;
   logic [SW-1:0]                ram_waddr;
   logic [dtq_pkg::WORD_W-1:0]   ram_wdata;
   logic [dtq_pkg::WORD_W-1:0]   ram_rdata;
   logic [TB-1:0]                rd_dl;
   logic [dtq_pkg::REF_W-1:0]    rd_ref;
   logic [dtq_pkg::HND_W-1:0]    rd_hnd;

   logic          in_range;
   logic          scan_more;
   logic          due;
   logic          later_ok;
   logic          check_go;
   logic          set_pending;
   logic          arm;
   logic [TB-1:0] delay;

   assign in_range  = 32'(slot_ff) < NS;
   assign scan_more = cnt_ff < CW'(NS);

   assign ram_we    = cmd.apply_op && (op_ff == dtq_pkg::OP_START) && in_range;
   assign ram_waddr = SW'(slot_ff);
   assign ram_wdata = {dl_ff, ref_ff, hnd_ff};
   assign rd_dl     = ram_rdata[dtq_pkg::WORD_W-1 -: TB];
   assign rd_ref    = ram_rdata[dtq_pkg::HND_W +: dtq_pkg::REF_W];
   assign rd_hnd    = ram_rdata[dtq_pkg::HND_W-1:0];

   dtq_ram #(
      .WIDTH (dtq_pkg::WORD_W),
      .DEPTH (NS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (cnt_ff[SW-1:0]),
      .rd_data (ram_rdata)
   );

   // post-operation check on the earliest deadline
   assign due         = best_dl_ff <= now_ff;
   assign later_ok    = (armed_time_ff == '0) || (best_dl_ff < armed_time_ff);
   assign check_go    = best_valid_ff && ((op_ff != dtq_pkg::OP_START) || later_ok);
   assign set_pending = check_go && due;
   assign arm         = check_go && !due && later_ok;
   assign delay       = best_dl_ff - now_ff;

   assign stat.req_valid  = req.valid;
   assign stat.scan_done  = !scan_more && !cmp_valid_ff;
   assign stat.due_expire = (op_ff == dtq_pkg::OP_EXPIRE) && best_valid_ff && due;
   assign stat.out_free   = !rsp_valid_ff || rsp.ready;

   assign req.ready = cmd.idle;

   always_comb begin
      active_in     = active_ff;
      armed_time_in = armed_time_ff;
      pending_in    = pending_ff;
      if (cmd.apply_op) begin
         case (op_ff)
            dtq_pkg::OP_START: begin
               if (in_range) begin
                  active_in[SW'(slot_ff)] = 1'b1;
               end
            end
            dtq_pkg::OP_CANCEL: begin
               if (in_range) begin
                  active_in[SW'(slot_ff)] = 1'b0;
               end
            end
            dtq_pkg::OP_TICK: begin
               armed_time_in = '0;
            end
            dtq_pkg::OP_EXPIRE: begin
               pending_in = 1'b0;
            end
            default: begin
               pending_in = pending_ff;
            end
         endcase
      end
      if (cmd.emit_exp) begin
         active_in[best_idx_ff] = 1'b0;
      end
      if (cmd.emit_status) begin
         if (set_pending) begin
            pending_in = 1'b1;
         end
         if (arm) begin
            armed_time_in = best_dl_ff;
         end
      end
   end

   always_comb begin
      cnt_in        = cnt_ff;
      cmp_valid_in  = 1'b0;
      best_valid_in = best_valid_ff;
      best_idx_in   = best_idx_ff;
      best_dl_in    = best_dl_ff;
      best_ref_in   = best_ref_ff;
      best_hnd_in   = best_hnd_ff;
      if (cmd.scan_start) begin
         cnt_in        = '0;
         best_valid_in = 1'b0;
      end else if (cmd.scan_run) begin
         if (scan_more) begin
            cnt_in       = cnt_ff + CW'(1);
            cmp_valid_in = 1'b1;
         end
         if (cmp_valid_ff && active_ff[cmp_idx_ff]
             && (!best_valid_ff || (rd_dl < best_dl_ff))) begin
            best_valid_in = 1'b1;
            best_idx_in   = cmp_idx_ff;
            best_dl_in    = rd_dl;
            best_ref_in   = rd_ref;
            best_hnd_in   = rd_hnd;
         end
      end
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp.ready) || cmd.emit_exp || cmd.emit_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         armed_time_ff <= '0;
         pending_ff    <= 1'b0;
         cnt_ff        <= '0;
         cmp_valid_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         active_ff     <= active_in;
         armed_time_ff <= armed_time_in;
         pending_ff    <= pending_in;
         cnt_ff        <= cnt_in;
         cmp_valid_ff  <= cmp_valid_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= dtq_pkg::op_type'(req.opcode);
         slot_ff <= req.timer_slot;
         dl_ff   <= TB'(req.deadline);
         ref_ff  <= req.owner_ref;
         hnd_ff  <= req.handler_tag;
         now_ff  <= TB'(req.now);
      end
      cmp_idx_ff  <= cnt_ff[SW-1:0];
      best_idx_ff <= best_idx_in;
      best_dl_ff  <= best_dl_in;
      best_ref_ff <= best_ref_in;
      best_hnd_ff <= best_hnd_in;
      if (cmd.emit_exp) begin
         kind_ff      <= dtq_pkg::KIND_EXPIRY;
         exp_slot_ff  <= 4'(best_idx_ff);
         exp_ref_ff   <= best_ref_ff;
         exp_hnd_ff   <= best_hnd_ff;
         pend_out_ff  <= 1'b0;
         armed_out_ff <= 1'b0;
         delay_out_ff <= '0;
         last_ff      <= 1'b0;
      end else if (cmd.emit_status) begin
         kind_ff      <= dtq_pkg::KIND_STATUS;
         exp_slot_ff  <= '0;
         exp_ref_ff   <= '0;
         exp_hnd_ff   <= '0;
         pend_out_ff  <= pending_in;
         armed_out_ff <= arm;
         delay_out_ff <= arm ? 32'(delay) : 32'd0;
         last_ff      <= 1'b1;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.kind            = kind_ff;
   assign rsp.expired_slot    = exp_slot_ff;
   assign rsp.expired_ref     = exp_ref_ff;
   assign rsp.expired_handler = exp_hnd_ff;
   assign rsp.expire_pending  = pend_out_ff;
   assign rsp.alarm_armed     = armed_out_ff;
   assign rsp.alarm_delay     = delay_out_ff;
   assign rsp.last            = last_ff;

endmodule
